/* rtl/afc_pkg.sv */
// Shared constants, field offsets and control types for the box-versus-frustum cull unit.
// No dependencies; every other file in rtl refers to this package by scoped names.
package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int NUM_COMP   = 4;
  localparam int MAT_DIM    = 4;
  localparam int IDX_W      = 2;
  localparam int COORD_W    = 32;
  localparam int EXTENT_W   = 31;
  localparam int Q_FRAC     = 16;

  // Input tdata layout, lowest bit first.
  localparam int COL_LSB    = 0;
  localparam int ROW_LSB    = 2;
  localparam int VAL_LSB    = 4;
  localparam int CTR_LSB    = 36;
  localparam int EXT_LSB    = 132;
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  // Load enables for the three register stages inside each plane lane.
  typedef struct packed {
    logic mul;
    logic merge;
    logic sum;
  } afc_adv_t;

endpackage

/* rtl/afc_plane_store.sv */
// Matrix store and the six extracted frustum planes, both cleared at reset.
// Depends on afc_pkg for dimensions and index widths.
module afc_plane_store #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [afc_pkg::IDX_W-1:0]     wr_row,
  input  logic [afc_pkg::IDX_W-1:0]     wr_col,
  input  logic signed [VALUE_WIDTH-1:0] wr_val,
  input  logic                          wr_last,
  output logic signed [VALUE_WIDTH:0]   plane [afc_pkg::NUM_PLANES][afc_pkg::NUM_COMP]
);

  logic signed [VALUE_WIDTH-1:0] mat      [afc_pkg::MAT_DIM][afc_pkg::MAT_DIM];
  logic signed [VALUE_WIDTH-1:0] mat_next [afc_pkg::MAT_DIM][afc_pkg::MAT_DIM];
  logic signed [VALUE_WIDTH:0]   plane_next [afc_pkg::NUM_PLANES][afc_pkg::NUM_COMP];

  // The element being written takes part in the extraction it triggers.
  always_comb begin
    for (int r = 0; r < afc_pkg::MAT_DIM; r++) begin
      for (int c = 0; c < afc_pkg::MAT_DIM; c++) begin
        if (wr_row == afc_pkg::IDX_W'(r) && wr_col == afc_pkg::IDX_W'(c)) begin
          mat_next[r][c] = wr_val;
        end else begin
          mat_next[r][c] = mat[r][c];
        end
      end
    end
  end

  // Plane 2a is row 3 plus row a, plane 2a+1 is row 3 minus row a.
  always_comb begin
    for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
      for (int k = 0; k < afc_pkg::NUM_COMP; k++) begin
        plane_next[2*a][k]   = (VALUE_WIDTH+1)'(mat_next[afc_pkg::NUM_AXES][k])
                             + (VALUE_WIDTH+1)'(mat_next[a][k]);
        plane_next[2*a+1][k] = (VALUE_WIDTH+1)'(mat_next[afc_pkg::NUM_AXES][k])
                             - (VALUE_WIDTH+1)'(mat_next[a][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < afc_pkg::MAT_DIM; r++) begin
        for (int c = 0; c < afc_pkg::MAT_DIM; c++) begin
          mat[r][c] <= '0;
        end
      end
      for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
        for (int k = 0; k < afc_pkg::NUM_COMP; k++) begin
          plane[p][k] <= '0;
        end
      end
    end else if (wr_en) begin
      mat <= mat_next;
      if (wr_last) begin
        plane <= plane_next;
      end
    end
  end

endmodule

/* rtl/afc_plane_lane.sv */
// One plane's datapath: signed partial products, term merge, and a two-level sum.
// Depends on afc_pkg for the stage enable struct and fixed field widths.
module afc_plane_lane #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  afc_pkg::afc_adv_t        adv,
  input  logic signed [VALUE_WIDTH:0] coeff [afc_pkg::NUM_COMP],
  input  logic signed [((VALUE_WIDTH > afc_pkg::EXTENT_W + 1) ? VALUE_WIDTH :
                        afc_pkg::EXTENT_W + 1):0] cpe [afc_pkg::NUM_AXES],
  input  logic signed [((VALUE_WIDTH > afc_pkg::EXTENT_W + 1) ? VALUE_WIDTH :
                        afc_pkg::EXTENT_W + 1):0] cme [afc_pkg::NUM_AXES],
  output logic                     neg
);

  localparam int MW    = ((VALUE_WIDTH > afc_pkg::EXTENT_W + 1) ? VALUE_WIDTH :
                          afc_pkg::EXTENT_W + 1) + 1;
  localparam int LO_W  = MW / 2;
  localparam int HI_W  = MW - LO_W;
  localparam int PLO_W = VALUE_WIDTH + LO_W + 2;
  localparam int PHI_W = VALUE_WIDTH + 1 + HI_W;
  localparam int SUM_W = VALUE_WIDTH + MW + 3;

  logic signed [MW-1:0]       m_sel [afc_pkg::NUM_AXES];
  logic        [LO_W-1:0]     m_lo  [afc_pkg::NUM_AXES];
  logic signed [HI_W-1:0]     m_hi  [afc_pkg::NUM_AXES];
  logic signed [PLO_W-1:0]    plo   [afc_pkg::NUM_AXES];
  logic signed [PHI_W-1:0]    phi   [afc_pkg::NUM_AXES];
  logic signed [VALUE_WIDTH:0] plane_d;
  logic signed [SUM_W-1:0]    term  [afc_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]    dist_sh;
  logic signed [SUM_W-1:0]    half_a;
  logic signed [SUM_W-1:0]    half_b;
  logic signed [SUM_W-1:0]    total;

  // n*c + |n|*e equals n*(c+e) for a non-negative normal and n*(c-e) otherwise.
  always_comb begin
    for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
      m_sel[k] = coeff[k][VALUE_WIDTH] ? cme[k] : cpe[k];
      m_lo[k]  = m_sel[k][LO_W-1:0];
      m_hi[k]  = $signed(m_sel[k][MW-1:LO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
        plo[k] <= coeff[k] * $signed({1'b0, m_lo[k]});
        phi[k] <= coeff[k] * m_hi[k];
      end
      plane_d <= coeff[afc_pkg::NUM_AXES];
    end
    if (adv.merge) begin
      for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
        term[k] <= (SUM_W'(phi[k]) <<< LO_W) + SUM_W'(plo[k]);
      end
      dist_sh <= SUM_W'(plane_d) <<< afc_pkg::Q_FRAC;
    end
    if (adv.sum) begin
      half_a <= term[0] + term[1];
      half_b <= term[2] + dist_sh;
    end
  end

  assign total = half_a + half_b;
  assign neg   = total[SUM_W-1];

endmodule

/* rtl/aabb_frustum_cull_unit.sv */
// Top level of the box-versus-frustum cull unit: input registers, plane store, six lanes.
// Depends on afc_pkg, afc_plane_store and afc_plane_lane.
//
// The unit takes one transaction per clock cycle on its input stream while the output side
// does not stall, and gives one result transaction for every box. A transaction with tuser
// low loads one element of the view-projection matrix; the element marked with tlast also
// rebuilds all six planes, including that element. Loads give no result. A transaction with
// tuser high tests one box (centre and half-sizes) and yields visible in bit 0 of the output
// tdata. The six stages are: input register, centre plus and minus extent, split signed
// multiplies (where loads also commit into the matrix and plane store, so every box sees
// exactly the planes of the loads taken before it), partial-product merge, pair sums, and the
// final sum whose sign bits form the output register. Throughput is one box per cycle while
// the output does not stall, set by six fully unrolled plane lanes; a stall on the output
// holds every full stage while empty stages still fill, so bubbles close up. Planes are not
// normalised and sums are exact, so a box that only touches a plane counts as visible, and a
// box tested before any matrix load is visible because the store resets to zero.
module aabb_frustum_cull_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // mat_col[1:0], mat_row[3:2], mat_value[35:4], center_x[67:36], center_y[99:68],
  // center_z[131:100], extent_x[162:132], extent_y[193:163], extent_z[224:194], zero fill
  input  logic [afc_pkg::IN_TDATA_W-1:0]     s_tdata,
  // kind: 0 loads one matrix element, 1 tests one box
  input  logic                               s_tuser,
  // mat_last
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // visible[0], zero fill
  output logic [afc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int MW = ((VALUE_WIDTH > afc_pkg::EXTENT_W + 1) ? VALUE_WIDTH :
                       afc_pkg::EXTENT_W + 1) + 1;

  // Stage valid bits and the ready chain.
  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;

  // Stage 1: registered input fields.
  logic                          s1_kind;
  logic [afc_pkg::IDX_W-1:0]     s1_row;
  logic [afc_pkg::IDX_W-1:0]     s1_col;
  logic signed [VALUE_WIDTH-1:0] s1_val;
  logic                          s1_last;
  logic signed [VALUE_WIDTH-1:0] s1_ctr [afc_pkg::NUM_AXES];
  logic [afc_pkg::EXTENT_W-1:0]  s1_ext [afc_pkg::NUM_AXES];

  // Stage 2: load fields pass through, boxes carry centre plus and minus extent.
  logic                          s2_kind;
  logic [afc_pkg::IDX_W-1:0]     s2_row;
  logic [afc_pkg::IDX_W-1:0]     s2_col;
  logic signed [VALUE_WIDTH-1:0] s2_val;
  logic                          s2_last;
  logic signed [MW-1:0]          s2_cpe [afc_pkg::NUM_AXES];
  logic signed [MW-1:0]          s2_cme [afc_pkg::NUM_AXES];

  logic                          store_wr;
  logic signed [VALUE_WIDTH:0]   plane [afc_pkg::NUM_PLANES][afc_pkg::NUM_COMP];
  afc_pkg::afc_adv_t             adv;
  logic [afc_pkg::NUM_PLANES-1:0] neg;
  logic                          visible;

  // A stage takes new data when it is empty or its content moves on.
  assign r6 = !v6 || m_tready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      // Loads finish at stage 2; only boxes travel on.
      if (r3) v3 <= v2 && (s2_kind == afc_pkg::KIND_BOX);
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // Centres and matrix values are wrapped to the working width on entry.
  always_ff @(posedge clk) begin
    if (r1) begin
      s1_kind <= s_tuser;
      s1_col  <= s_tdata[afc_pkg::COL_LSB +: afc_pkg::IDX_W];
      s1_row  <= s_tdata[afc_pkg::ROW_LSB +: afc_pkg::IDX_W];
      s1_val  <= VALUE_WIDTH'($signed(s_tdata[afc_pkg::VAL_LSB +: afc_pkg::COORD_W]));
      s1_last <= s_tlast;
      for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
        s1_ctr[k] <= VALUE_WIDTH'($signed(
                       s_tdata[afc_pkg::CTR_LSB + k*afc_pkg::COORD_W +: afc_pkg::COORD_W]));
        s1_ext[k] <= s_tdata[afc_pkg::EXT_LSB + k*afc_pkg::EXTENT_W +: afc_pkg::EXTENT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_kind <= s1_kind;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_val  <= s1_val;
      s2_last <= s1_last;
      for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
        s2_cpe[k] <= MW'(s1_ctr[k]) + MW'($signed({1'b0, s1_ext[k]}));
        s2_cme[k] <= MW'(s1_ctr[k]) - MW'($signed({1'b0, s1_ext[k]}));
      end
    end
  end

  // Loads commit on the same edge at which boxes read the planes, which keeps order.
  assign store_wr = v2 && (s2_kind == afc_pkg::KIND_LOAD) && r3;

  afc_plane_store #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_wr),
    .wr_row  (s2_row),
    .wr_col  (s2_col),
    .wr_val  (s2_val),
    .wr_last (s2_last),
    .plane   (plane)
  );

  assign adv.mul   = r3;
  assign adv.merge = r4;
  assign adv.sum   = r5;

  for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_lane
    afc_plane_lane #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lane (
      .clk   (clk),
      .adv   (adv),
      .coeff (plane[p]),
      .cpe   (s2_cpe),
      .cme   (s2_cme),
      .neg   (neg[p])
    );
  end

  // The box is culled when any plane sum is strictly negative.
  always_ff @(posedge clk) begin
    if (r6) begin
      visible <= ~|neg;
    end
  end

  assign m_tvalid = v6;
  assign m_tdata  = {(afc_pkg::OUT_TDATA_W-1)'(0), visible};

endmodule

/* rtl/afc_checker.sv */
// Port-level checks for the cull unit, attached to the top level by a bind statement.
// Depends on afc_pkg for the output tdata width.
module afc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [afc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // Reset empties the pipeline, so no result shows in the cycle after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  // With the output register free, every stage can take data, so input is accepted.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled although the output side is free");

  // Only bit 0 carries a field; the rest is zero fill.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[afc_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("output fill bits not zero");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output transaction withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("output data changed while stalled");

endmodule

bind aabb_frustum_cull_unit afc_checker u_afc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
